/* src/cds_pkg.sv */
// Package for the centered decimating scaler: field widths, register
// indexes, reset values and the divide-by-100 reciprocal constants.
// No dependencies.
`default_nettype none
package cds_pkg;

   localparam int COORD_W    = 10;
   localparam int PIX_W      = 32;
   localparam int SIZE_W     = 11;
   localparam int PCT_W      = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;
   localparam int TDATA_W    = 56;
   localparam int SAT_W      = 13;

   // d * pct fits in 17 bits; floor(x / 100) = (x * RECIP_MULT) >> RECIP_SHIFT
   // is exact for all x below 2^17.
   localparam int PROD_W      = 17;
   localparam int RECIP_W     = 18;
   localparam int RECIP_SHIFT = 24;
   localparam int QM_W        = PROD_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_MULT = 18'd167773;

   localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

   localparam logic [CSR_IDX_W-1:0] REG_SCALE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT = 2'd2;

   localparam logic [PCT_W-1:0]  SCALE_RST  = 7'd100;
   localparam logic [SIZE_W-1:0] WIDTH_RST  = 11'd640;
   localparam logic [SIZE_W-1:0] HEIGHT_RST = 11'd480;

   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [SIZE_W-1:0]  size_type;
   typedef logic [PROD_W-1:0]  prod_type;
   typedef logic [PIX_W-1:0]   pixel_type;

endpackage
`default_nettype wire

/* src/centered_decimating_scaler.sv */
// Centered decimating scaler, top level: four-stage mapping pipeline.
// Depends on cds_pkg.
//
// Usage:
//   req_* carries one source pixel per beat (column, row, value). rsp_* returns
//   exactly one beat per request, in order: tuser is the write enable, tdata the
//   destination column, row and pixel value (all zero when nothing is written).
//   csr_* writes scale_percent (0), image_width (1) and image_height (2); write
//   only while the pipeline is empty.
//   Throughput: one beat per cycle while the receiver does not stall; stages
//   are distance, d*pct, reciprocal multiply for /100, then remainder check
//   and output register. Each stage holds its beat while the next one is full,
//   so a stalled receiver backs the pipeline up to req_tready without loss;
//   bubbles are squeezed out on the way.
//   Reset clears all valid bits and loads 100 percent, 640 x 480.
`default_nettype none
module centered_decimating_scaler #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int PIXEL_BITS = 32
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [cds_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [cds_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // src_column[9:0], src_row[19:10], src_pixel[51:20], zero[55:52]
   input  wire logic [cds_pkg::TDATA_W-1:0]      req_tdata,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // dest_column[9:0], dest_row[19:10], dest_pixel[51:20], zero[55:52]
   output logic [cds_pkg::TDATA_W-1:0]           rsp_tdata,
   // write_enable[0]
   output logic [0:0]                            rsp_tuser
);

   localparam logic [cds_pkg::PIX_W-1:0] PIX_MASK =
      cds_pkg::PIX_W'((64'd1 << PIXEL_BITS) - 64'd1);

   // configuration
   logic [cds_pkg::PCT_W-1:0] scale_ff;
   cds_pkg::size_type         width_ff, height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff  <= cds_pkg::SCALE_RST;
         width_ff  <= cds_pkg::WIDTH_RST;
         height_ff <= cds_pkg::HEIGHT_RST;
      end else if (csr_we) begin
         case (csr_index)
            cds_pkg::REG_SCALE:  scale_ff  <= csr_wdata[cds_pkg::PCT_W-1:0];
            cds_pkg::REG_WIDTH:  width_ff  <= csr_wdata;
            cds_pkg::REG_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [cds_pkg::PCT_W-1:0] pct;
   cds_pkg::size_type         size_sat [2];
   cds_pkg::coord_type        half     [2];

   always_comb begin
      pct = (scale_ff > cds_pkg::PCT_FULL) ? cds_pkg::PCT_FULL : scale_ff;
      size_sat[0] = ({2'b00, width_ff} > cds_pkg::SAT_W'(MAX_WIDTH)) ?
                    cds_pkg::SIZE_W'(MAX_WIDTH) : width_ff;
      size_sat[1] = ({2'b00, height_ff} > cds_pkg::SAT_W'(MAX_HEIGHT)) ?
                    cds_pkg::SIZE_W'(MAX_HEIGHT) : height_ff;
      for (int a = 0; a < 2; a++) begin
         half[a] = size_sat[a][cds_pkg::SIZE_W-1:1];
      end
   end

   // flow control
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic rdy1, rdy2, rdy3, rdy4;

   always_comb begin
      rdy4 = !s4_valid_ff || rsp_tready;
      rdy3 = !s3_valid_ff || rdy4;
      rdy2 = !s2_valid_ff || rdy3;
      rdy1 = !s1_valid_ff || rdy2;
   end

   assign req_tready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (rdy1) s1_valid_ff <= req_tvalid;
         if (rdy2) s2_valid_ff <= s1_valid_ff;
         if (rdy3) s3_valid_ff <= s2_valid_ff;
         if (rdy4) s4_valid_ff <= s3_valid_ff;
      end
   end

   // stage 1: range check, side, distance from the center line
   cds_pkg::coord_type pos [2];
   logic               s1_ok_in [2], s1_low_in [2];
   cds_pkg::coord_type s1_d_in [2];
   cds_pkg::pixel_type s1_pix_in;
   logic               s1_ok_ff [2], s1_low_ff [2];
   cds_pkg::coord_type s1_d_ff [2];
   cds_pkg::pixel_type s1_pix_ff;

   always_comb begin
      pos[0]    = req_tdata[9:0];
      pos[1]    = req_tdata[19:10];
      s1_pix_in = req_tdata[51:20] & PIX_MASK;
      for (int a = 0; a < 2; a++) begin
         s1_ok_in[a]  = {1'b0, pos[a]} < size_sat[a];
         s1_low_in[a] = pos[a] < half[a];
         s1_d_in[a]   = s1_low_in[a] ? (half[a] - cds_pkg::COORD_W'(1) - pos[a])
                                     : (pos[a] - half[a]);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_ok_ff  <= s1_ok_in;
         s1_low_ff <= s1_low_in;
         s1_d_ff   <= s1_d_in;
         s1_pix_ff <= s1_pix_in;
      end
   end

   // stage 2: d * pct
   cds_pkg::prod_type  s2_prod_in [2];
   cds_pkg::prod_type  s2_prod_ff [2];
   logic               s2_ok_ff [2], s2_low_ff [2];
   cds_pkg::pixel_type s2_pix_ff;

   always_comb begin
      for (int a = 0; a < 2; a++) begin
         s2_prod_in[a] = cds_pkg::PROD_W'(s1_d_ff[a]) * cds_pkg::PROD_W'(pct);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         s2_prod_ff <= s2_prod_in;
         s2_ok_ff   <= s1_ok_ff;
         s2_low_ff  <= s1_low_ff;
         s2_pix_ff  <= s1_pix_ff;
      end
   end

   // stage 3: quotient by 100 through the reciprocal
   logic [cds_pkg::QM_W-1:0] qm [2];
   cds_pkg::coord_type s3_q_in [2];
   cds_pkg::coord_type s3_q_ff [2];
   cds_pkg::prod_type  s3_prod_ff [2];
   logic               s3_ok_ff [2], s3_low_ff [2];
   cds_pkg::pixel_type s3_pix_ff;

   always_comb begin
      for (int a = 0; a < 2; a++) begin
         qm[a]      = cds_pkg::QM_W'(s2_prod_ff[a]) * cds_pkg::QM_W'(cds_pkg::RECIP_MULT);
         s3_q_in[a] = qm[a][cds_pkg::RECIP_SHIFT +: cds_pkg::COORD_W];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         s3_q_ff    <= s3_q_in;
         s3_prod_ff <= s2_prod_ff;
         s3_ok_ff   <= s2_ok_ff;
         s3_low_ff  <= s2_low_ff;
         s3_pix_ff  <= s2_pix_ff;
      end
   end

   // stage 4: keep test from the remainder, destination, output register
   cds_pkg::prod_type  rem  [2];
   logic               keep [2];
   cds_pkg::coord_type dest [2];
   logic               out_we_in;
   logic [cds_pkg::TDATA_W-1:0] out_data_in;
   logic               out_we_ff;
   logic [cds_pkg::TDATA_W-1:0] out_data_ff;

   always_comb begin
      for (int a = 0; a < 2; a++) begin
         rem[a]  = s3_prod_ff[a] -
                   cds_pkg::PROD_W'(s3_q_ff[a]) * cds_pkg::PROD_W'(cds_pkg::PCT_FULL);
         keep[a] = ({1'b0, rem[a][cds_pkg::PCT_W-1:0]} + {1'b0, pct}) >=
                   {1'b0, cds_pkg::PCT_FULL};
         dest[a] = s3_low_ff[a] ? (half[a] - cds_pkg::COORD_W'(1) - s3_q_ff[a])
                                : (half[a] + s3_q_ff[a]);
      end
      out_we_in   = s3_ok_ff[0] && s3_ok_ff[1] && keep[0] && keep[1];
      out_data_in = out_we_in ? {4'b0000, s3_pix_ff, dest[1], dest[0]} : '0;
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         out_we_ff   <= out_we_in;
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid   = s4_valid_ff;
   assign rsp_tdata    = out_data_ff;
   assign rsp_tuser[0] = out_we_ff;

   // checks
   a_accept_enters : assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> s1_valid_ff)
      else $error("accepted beat did not enter the pipeline");

   a_nowrite_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("non-write result carries data");

   a_zero_pct : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && scale_ff == '0 |-> !rsp_tuser[0])
      else $error("write at zero percent");

   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff && !rdy3 |=> s3_valid_ff)
      else $error("stalled stage lost its beat");

endmodule
`default_nettype wire

/* test/scaler_check_pkg.sv */
`timescale 1ns / 1ps
// Scoreboard for the centered decimating scaler bench: predicts where each
// source pixel lands and checks response beats in order. Depends on cds_pkg.
package scaler_check_pkg;
   import cds_pkg::*;

   localparam int unsigned WIDTH_LIMIT  = 1024;
   localparam int unsigned HEIGHT_LIMIT = 1024;

   typedef struct {
      logic      write_enable;
      coord_type dest_column;
      coord_type dest_row;
      pixel_type dest_pixel;
   } dest_beat_type;

   class scaler_scoreboard;
      logic [PCT_W-1:0]  scale_percent;
      logic [SIZE_W-1:0] image_width;
      logic [SIZE_W-1:0] image_height;
      dest_beat_type     expected_beats[$];
      int unsigned       failures;

      function new();
         scale_percent = SCALE_RST;
         image_width   = WIDTH_RST;
         image_height  = HEIGHT_RST;
         failures      = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] index,
                                   logic [CSR_DATA_W-1:0] value);
         case (index)
            REG_SCALE:  scale_percent = value[PCT_W-1:0];
            REG_WIDTH:  image_width   = value[SIZE_W-1:0];
            REG_HEIGHT: image_height  = value[SIZE_W-1:0];
            default: ;
         endcase
      endfunction

      // distance from the center line on the pixel's own side, kept when the
      // scaled distance steps up
      function bit map_axis(int unsigned pos, int unsigned size, int unsigned pct,
                            output int unsigned dest);
         int unsigned half, offset, lo, hi;
         half = size >> 1;
         dest = 0;
         if (pos >= size) return 1'b0;
         offset = (pos < half) ? half - 1 - pos : pos - half;
         lo     = (offset * pct) / 100;
         hi     = ((offset + 1) * pct) / 100;
         if (hi <= lo) return 1'b0;
         dest = (pos < half) ? half - 1 - lo : half + lo;
         return 1'b1;
      endfunction

      function void note_pixel(coord_type column, coord_type row, pixel_type value);
         int unsigned   pct, width, height, dc, dr;
         dest_beat_type beat;
         pct    = (scale_percent > PCT_FULL) ? 100 : scale_percent;
         width  = (image_width > WIDTH_LIMIT) ? WIDTH_LIMIT : image_width;
         height = (image_height > HEIGHT_LIMIT) ? HEIGHT_LIMIT : image_height;
         beat.write_enable = 1'b0;
         beat.dest_column  = '0;
         beat.dest_row     = '0;
         beat.dest_pixel   = '0;
         if (map_axis(column, width, pct, dc) && map_axis(row, height, pct, dr)) begin
            beat.write_enable = 1'b1;
            beat.dest_column  = dc[COORD_W-1:0];
            beat.dest_row     = dr[COORD_W-1:0];
            beat.dest_pixel   = value;
         end
         expected_beats.push_back(beat);
      endfunction

      function void compare_field(string name, logic [PIX_W-1:0] want,
                                  logic [PIX_W-1:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            failures++;
         end
      endfunction

      function void check_beat(logic write_enable, coord_type dest_column,
                               coord_type dest_row, pixel_type dest_pixel);
         dest_beat_type want;
         if (expected_beats.size() == 0) begin
            $display("%0t: response beat expected none, got we %0h col %0h row %0h pixel %0h",
                     $time, write_enable, dest_column, dest_row, dest_pixel);
            failures++;
            return;
         end
         want = expected_beats.pop_front();
         compare_field("write_enable", want.write_enable, write_enable);
         compare_field("dest_column", want.dest_column, dest_column);
         compare_field("dest_row", want.dest_row, dest_row);
         compare_field("dest_pixel", want.dest_pixel, dest_pixel);
      endfunction

      function int unsigned pending();
         return expected_beats.size();
      endfunction
   endclass

endpackage

/* test/tb.sv */
`timescale 1ns / 1ps
// Top-level bench for centered_decimating_scaler: directed and random pixel
// streams under several scale and size settings, random stalls on both sides.
// Depends on cds_pkg and scaler_check_pkg.
module tb;
   import cds_pkg::*;
   import scaler_check_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int unsigned PHASES        = 10;
   localparam int unsigned PHASE_PIXELS  = 45;
   localparam int unsigned HOLD_PHASE    = 1;
   localparam int unsigned HOLD_CYCLES   = 300;
   localparam int unsigned TAIL_CYCLES   = 12;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [TDATA_W-1:0]    req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [TDATA_W-1:0]    rsp_tdata;
   logic [0:0]            rsp_tuser;

   logic                  hold_off_request = 1'b0;
   int unsigned           cycle_count = 0;
   logic [SIZE_W-1:0]     cur_width = WIDTH_RST;
   logic [SIZE_W-1:0]     cur_height = HEIGHT_RST;
   scaler_scoreboard      sb = new();

   centered_decimating_scaler dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("centered_decimating_scaler regression: fail");
      $finish;
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(15, 50);
   endfunction

   function automatic coord_type pick_coord(logic [SIZE_W-1:0] size);
      int unsigned span, r;
      span = (size > WIDTH_LIMIT) ? WIDTH_LIMIT : size;
      r    = $urandom_range(0, 99);
      if (span == 0 || r >= 85) return coord_type'($urandom_range(0, 1023));
      if (r < 15) begin
         case ($urandom_range(0, 3))
            0: return coord_type'(0);
            1: return coord_type'(span - 1);
            2: return coord_type'(span / 2);
            default: return coord_type'((span >= 2) ? span / 2 - 1 : 0);
         endcase
      end
      return coord_type'($urandom_range(0, span - 1));
   endfunction

   function automatic logic [SIZE_W-1:0] pick_size();
      case ($urandom_range(0, 7))
         0: return SIZE_W'($urandom_range(0, 3));
         1: return SIZE_W'($urandom_range(4, 40));
         2: return SIZE_W'(1024);
         3: return SIZE_W'($urandom_range(1025, 2047));
         default: return SIZE_W'($urandom_range(1, 1024));
      endcase
   endfunction

   // scale register ignores the upper data bits
   function automatic logic [CSR_DATA_W-1:0] pick_scale();
      logic [CSR_DATA_W-1:0] value;
      value = CSR_DATA_W'($urandom_range(0, 127));
      if ($urandom_range(0, 3) == 0) value[CSR_DATA_W-1:PCT_W] = 4'($urandom);
      return value;
   endfunction

   task automatic write_csr(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_register(index, value);
   endtask

   task automatic configure(logic [CSR_DATA_W-1:0] scale, logic [SIZE_W-1:0] width,
                            logic [SIZE_W-1:0] height, bit touch_spare);
      write_csr(REG_SCALE, scale);
      write_csr(REG_WIDTH, width);
      write_csr(REG_HEIGHT, height);
      if (touch_spare) write_csr(REG_SPARE, CSR_DATA_W'($urandom));
      csr_we     <= 1'b0;
      cur_width  = width;
      cur_height = height;
   endtask

   task automatic idle_sender(int unsigned cycles);
      if (cycles != 0) begin
         req_tvalid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic send_pixel(coord_type column, coord_type row, pixel_type value);
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, value, row, column};
      do @(posedge clock); while (!req_tready);
      sb.note_pixel(column, row, value);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // response side: checks every beat, random back-pressure, one long hold
   initial begin
      int unsigned hold_left, quiet_left, stall_left, r;
      bit          hold_done;
      hold_left  = 0;
      quiet_left = 0;
      stall_left = 0;
      hold_done  = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            sb.check_beat(rsp_tuser[0], rsp_tdata[9:0], rsp_tdata[19:10], rsp_tdata[51:20]);
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (hold_off_request && !hold_done) begin
            hold_done  = 1'b1;
            hold_left  = HOLD_CYCLES - 1;
            rsp_tready <= 1'b0;
         end else if (quiet_left != 0) begin
            quiet_left--;
            rsp_tready <= 1'b1;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
               rsp_tready <= 1'b1;
            end else if (r < 55) begin
               quiet_left = $urandom_range(20, 80);
               rsp_tready <= 1'b1;
            end else if (r < 95) begin
               stall_left = $urandom_range(0, 2);
               rsp_tready <= 1'b0;
            end else begin
               stall_left = $urandom_range(19, 49);
               rsp_tready <= 1'b0;
            end
         end
      end
   end

   initial begin
      logic [CSR_DATA_W-1:0] scale;
      logic [SIZE_W-1:0]     width, height;
      bit                    no_gaps;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset setting: 100 percent, 640 x 480
      send_pixel(10'd0, 10'd0, 32'h0000_0000);
      send_pixel(10'd639, 10'd479, 32'hFFFF_FFFF);
      send_pixel(10'd319, 10'd239, 32'hAAAA_AAAA);
      send_pixel(10'd320, 10'd240, 32'h5555_5555);
      send_pixel(10'd640, 10'd0, 32'h1234_5678);
      send_pixel(10'd0, 10'd480, 32'h8765_4321);
      send_pixel(10'd1023, 10'd1023, 32'hFFFF_FFFF);
      send_pixel(10'd1023, 10'd0, 32'h0000_0001);
      drain();

      // zero percent writes nothing
      configure(11'd0, 11'd640, 11'd480, 1'b0);
      send_pixel(10'd319, 10'd239, 32'hDEAD_BEEF);
      send_pixel(10'd0, 10'd0, 32'hCAFE_F00D);
      drain();

      // above 100 percent and oversized image saturate
      configure({4'b1010, 7'd127}, 11'd2047, 11'd2047, 1'b1);
      send_pixel(10'd1023, 10'd1023, 32'hFFFF_FFFF);
      send_pixel(10'd0, 10'd0, 32'h0F0F_0F0F);
      send_pixel(10'd511, 10'd512, 32'hF0F0_F0F0);
      drain();

      // one percent keeps a pixel only where the scaled distance steps up
      configure(11'd1, 11'd1024, 11'd1024, 1'b0);
      send_pixel(10'd511, 10'd512, 32'h1111_1111);
      send_pixel(10'd412, 10'd611, 32'h2222_2222);
      send_pixel(10'd12, 10'd1011, 32'h3333_3333);
      send_pixel(10'd1023, 10'd0, 32'h4444_4444);
      drain();

      // zero-width image, a one-pixel image and a one-by-two image
      configure(11'd50, 11'd0, 11'd1, 1'b0);
      send_pixel(10'd0, 10'd0, 32'h9999_9999);
      drain();
      configure(11'd33, 11'd1, 11'd1, 1'b0);
      send_pixel(10'd0, 10'd0, 32'h7777_7777);
      drain();
      configure(11'd100, 11'd1, 11'd2, 1'b0);
      send_pixel(10'd0, 10'd0, 32'h6666_6666);
      send_pixel(10'd0, 10'd1, 32'h5A5A_5A5A);
      drain();

      for (int unsigned ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin scale = 11'd100; width = 11'd1024; height = 11'd1024; end
            1: begin scale = 11'd50;  width = 11'd640;  height = 11'd480;  end
            2: begin scale = 11'd0;   width = 11'd16;   height = 11'd16;   end
            3: begin scale = 11'd1;   width = 11'd1024; height = 11'd1024; end
            4: begin scale = {4'b0101, 7'd127}; width = 11'd2047; height = 11'd1025; end
            5: begin scale = 11'd33;  width = 11'd7;    height = 11'd5;    end
            6: begin scale = 11'd99;  width = 11'd1;    height = 11'd2;    end
            7: begin scale = 11'd75;  width = 11'd0;    height = 11'd3;    end
            default: begin scale = pick_scale(); width = pick_size(); height = pick_size(); end
         endcase
         configure(scale, width, height, ph == 5);
         if (ph == HOLD_PHASE) hold_off_request <= 1'b1;
         no_gaps = (ph == HOLD_PHASE) || ($urandom_range(0, 3) == 0);
         for (int unsigned n = 0; n < PHASE_PIXELS; n++) begin
            if (!no_gaps || (ph == HOLD_PHASE && n >= 40)) idle_sender(pick_gap());
            send_pixel(pick_coord(cur_width), pick_coord(cur_height), pixel_type'($urandom));
         end
         drain();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("centered_decimating_scaler regression: pass");
      end else begin
         $display("centered_decimating_scaler regression: fail");
      end
      $finish;
   end

endmodule
